[hw/rtl/srb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

    localparam int unsigned POS_W   = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PEND_W  = 6;
    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned S_USER_W = 2;
    localparam int unsigned M_DATA_W = 80;
    localparam int unsigned M_USER_W = 1;

    // tuser bit positions on the slave side
    localparam int unsigned S_USER_HAS_BYTE = 0;
    localparam int unsigned S_USER_EOF      = 1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic store;        // park the accepted item, update the end marker
        logic load_byte;    // release the byte at the head into the output register
        logic load_status;  // load a status result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic can_release;  // head slot holds a byte and the end is not reached
        logic more;         // after releasing the head, the next slot can go too
        logic ended_after;  // after releasing the head, the stream has ended
        logic out_free;     // output register can take a result this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

[hw/rtl/srb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module srb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/srb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module srb_ctrl
    import srb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_valid,
    output logic         o_s_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.store = 1'b1;
                    n_state     = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // head read is issued here; its data is ready in EMIT
                if (i_sts.can_release) begin
                    n_state = ST_EMIT;
                end else if (i_sts.out_free) begin
                    o_cmd.load_status = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    if (i_sts.more) begin
                        n_state = ST_EMIT;
                    end else if (i_sts.ended_after) begin
                        n_state = ST_LOOKUP;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_ready = (r_state == ST_IDLE);

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.store, o_cmd.load_byte, o_cmd.load_status}))
        else $error("datapath commands overlap");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_byte || o_cmd.load_status) |-> i_sts.out_free)
        else $error("result loaded into a full output register");

    a_status_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_status |-> !i_sts.can_release)
        else $error("status result while a byte is releasable");

endmodule

`default_nettype wire

[hw/rtl/srb_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module srb_dp
    import srb_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic [S_DATA_W-1:0] i_s_data,
    input  wire logic [S_USER_W-1:0] i_s_user,
    input  wire logic                i_s_last,
    input  wire logic                i_m_ready,
    output logic                     o_m_valid,
    output logic      [M_DATA_W-1:0] o_m_data,
    output logic      [M_USER_W-1:0] o_m_user,
    output logic                     o_m_last
);

    localparam int unsigned IDX_W = $clog2(CAPACITY);

    // unpacked input item
    logic [POS_W-1:0]  in_pos;
    logic [BYTE_W-1:0] in_byte;
    logic              in_has_byte;
    logic              in_eof;

    assign in_pos      = i_s_data[POS_W-1:0];
    assign in_byte     = i_s_data[POS_W +: BYTE_W];
    assign in_has_byte = i_s_user[S_USER_HAS_BYTE];
    assign in_eof      = i_s_user[S_USER_EOF];

    // reassembly state
    logic [CAPACITY-1:0] r_valid;
    logic [IDX_W-1:0]    r_head;
    logic [POS_W-1:0]    r_asm;
    logic [PEND_W-1:0]   r_pend;
    logic                r_end_known;
    logic [POS_W-1:0]    r_end_pos;
    logic                r_ended;

    // output register
    logic                r_m_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_valid;
    logic                r_out_ended;
    logic [POS_W-1:0]    r_out_asm;
    logic [PEND_W-1:0]   r_out_pend;
    logic                r_out_none;
    logic                r_out_last;

    // store path
    logic [POS_W-1:0]  diff;
    logic [IDX_W:0]    slot_sum;
    logic [IDX_W-1:0]  slot;
    logic              keep;
    logic              do_write;
    logic [POS_W-1:0]  new_end;

    assign diff     = in_pos - r_asm;
    assign slot_sum = {1'b0, r_head} + {1'b0, diff[IDX_W-1:0]};
    assign slot     = (slot_sum >= (IDX_W+1)'(CAPACITY))
                    ? IDX_W'(slot_sum - (IDX_W+1)'(CAPACITY))
                    : IDX_W'(slot_sum);
    assign keep     = in_has_byte
                    && (in_pos >= r_asm)
                    && (diff < POS_W'(CAPACITY))
                    && !(r_end_known && (in_pos >= r_end_pos));
    assign do_write = i_cmd.store && keep && !r_valid[slot];
    // end position saturates at all ones
    assign new_end  = (in_has_byte && (in_pos != '1)) ? in_pos + 1'b1 : in_pos;

    // release path
    logic                at_end;
    logic [POS_W-1:0]    nxt_asm;
    logic                nxt_at_end;
    logic [IDX_W-1:0]    head_inc;
    logic [IDX_W-1:0]    n_head;
    logic [CAPACITY-1:0] valid_after;
    logic                ended_after;
    logic                ended_now;
    logic [PEND_W-1:0]   pend_dec;
    logic [BYTE_W-1:0]   rd_byte;

    assign at_end      = r_end_known && (r_asm == r_end_pos);
    assign nxt_asm     = r_asm + 1'b1;
    assign nxt_at_end  = r_end_known && (nxt_asm == r_end_pos);
    // head restarts at slot zero when the position wraps
    assign head_inc    = ((r_head == IDX_W'(CAPACITY - 1)) || (r_asm == '1))
                       ? '0 : r_head + 1'b1;
    assign n_head      = i_cmd.load_byte ? head_inc : r_head;
    assign valid_after = r_valid & ~(CAPACITY'(1) << r_head);
    assign ended_after = r_ended || nxt_at_end;
    assign ended_now   = r_ended || at_end;
    assign pend_dec    = (r_pend != '0) ? r_pend - 1'b1 : r_pend;

    assign o_sts.can_release = r_valid[r_head] && !at_end;
    assign o_sts.more        = valid_after[head_inc] && !nxt_at_end;
    assign o_sts.ended_after = ended_after;
    assign o_sts.out_free    = !r_m_valid || i_m_ready;

    srb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (slot),
        .i_wdata (in_byte),
        .i_raddr (n_head),
        .o_rdata (rd_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_head      <= '0;
            r_asm       <= '0;
            r_pend      <= '0;
            r_end_known <= 1'b0;
            r_end_pos   <= '0;
            r_ended     <= 1'b0;
        end else begin
            if (do_write) begin
                r_valid[slot] <= 1'b1;
                r_pend        <= r_pend + 1'b1;
            end
            if (i_cmd.store && i_s_last && in_eof) begin
                r_end_known <= 1'b1;
                r_end_pos   <= new_end;
            end
            if (i_cmd.load_byte) begin
                r_valid[r_head] <= 1'b0;
                r_head          <= head_inc;
                r_asm           <= nxt_asm;
                r_pend          <= pend_dec;
                r_ended         <= ended_after;
            end
            if (i_cmd.load_status) begin
                r_ended <= ended_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.load_byte || i_cmd.load_status) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_out_byte  <= rd_byte;
            r_out_valid <= 1'b1;
            r_out_ended <= 1'b0;
            r_out_asm   <= nxt_asm;
            r_out_pend  <= pend_dec;
            r_out_none  <= (pend_dec == '0);
            r_out_last  <= !o_sts.more && !ended_after;
        end else if (i_cmd.load_status) begin
            r_out_byte  <= '0;
            r_out_valid <= 1'b0;
            r_out_ended <= ended_now;
            r_out_asm   <= r_asm;
            r_out_pend  <= r_pend;
            r_out_none  <= (r_pend == '0);
            r_out_last  <= 1'b1;
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = {r_out_none, r_out_pend, r_out_asm, r_out_ended, r_out_byte};
    assign o_m_user  = r_out_valid;
    assign o_m_last  = r_out_last;

    a_pend_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == PEND_W'($countones(r_valid)))
        else $error("pending count out of step with slot valid bits");

    a_head_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < IDX_W'(CAPACITY - 1) || r_head == IDX_W'(CAPACITY - 1))
        else $error("head slot outside the ring");

    a_ended_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !($past(i_rst_n) && $fell(r_ended)))
        else $error("ended flag cleared");

endmodule

`default_nettype wire

[hw/rtl/stream_reorder_buffer_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Stream reorder buffer. Each slave transfer carries one stream byte with its
// absolute 64-bit position, or a marker with no byte that closes an empty
// segment. Bytes inside the window [assembled, assembled + CAPACITY) are parked
// in a ring of CAPACITY slots; bytes below the assembled point, beyond the
// window or at or past a known end are dropped, and a duplicate never replaces
// a byte already held. An eof on a segment's last item sets the end position.
// After each input the block releases every newly contiguous byte in order, one
// master transfer per byte, then a status transfer (tuser low) when no byte was
// released or the stream has ended; tlast marks the final transfer of an input.
// Timing: an input is taken in the idle state, then the head slot is looked up.
// Released bytes then stream out at one per cycle unless the master side holds
// them back, paced by the byte store's single registered read port, and a final
// status transfer follows once the end is reached. The slave side is ready only
// between inputs, but a finished result may still sit in the output register
// while the next input is taken. There is no clearing pass after reset.
module stream_reorder_buffer_core
    import srb_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // [63:0] stream_pos, [71:64] byte_value
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // [0] has_byte, [1] eof
    input  wire logic [S_USER_W-1:0] s_axis_tuser,
    // segment_last
    input  wire logic                s_axis_tlast,

    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [7:0] out_byte, [8] stream_ended, [72:9] assembled_count,
    // [78:73] pending_count, [79] nothing_pending
    output logic      [M_DATA_W-1:0] m_axis_tdata,
    // [0] out_valid
    output logic      [M_USER_W-1:0] m_axis_tuser,
    // last result of the current input
    output logic                     m_axis_tlast
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller: sequence accept, head lookup, byte release and status transfer
    srb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // Datapath: window checks, slot ring, byte store, counters, output register
    srb_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_s_data  (s_axis_tdata),
        .i_s_user  (s_axis_tuser),
        .i_s_last  (s_axis_tlast),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_m_data  (m_axis_tdata),
        .o_m_user  (m_axis_tuser),
        .o_m_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

[tb/sv/stream_reorder_buffer_core_tb.sv]
`timescale 1ns / 1ps

module stream_reorder_buffer_core_tb;
    import srb_pkg::*;

    localparam int CAP = 32;

    // One stream item as it enters the slave side
    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] val;
        logic              has;
        logic              seg_last;
        logic              eof;
    } t_seg_item;

    // One result as it leaves the master side
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              carries;
        logic              ended;
        logic [POS_W-1:0]  assembled;
        logic [PEND_W-1:0] pend;
        logic              none_pend;
        logic              last;
    } t_rel_word;

    // Directed row; fixed marks a result typed in by hand
    typedef struct packed {
        t_seg_item item;
        logic      fixed;
        t_rel_word want;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;   // [63:0] stream_pos, [71:64] byte_value
    logic [S_USER_W-1:0] s_axis_tuser;   // [0] has_byte, [1] eof
    logic                s_axis_tlast;   // segment_last
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;   // [7:0] byte, [8] ended, [72:9] assembled,
                                         // [78:73] pending, [79] nothing_pending
    logic [M_USER_W-1:0] m_axis_tuser;   // [0] out_valid
    logic                m_axis_tlast;   // final result of an input

    stream_reorder_buffer_core #(.CAPACITY(CAP)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow of the reassembly state
    logic [BYTE_W-1:0] held_byte [CAP];
    logic              held_ok   [CAP];
    logic [POS_W-1:0]  asm_pos;
    int                pend_cnt;
    logic              end_set;
    logic [POS_W-1:0]  end_at;
    logic              stream_done;

    t_rel_word release_q [$];   // results still owed by the block, oldest first
    t_rel_word step_out  [$];   // results of the input just predicted
    t_dir_row  dir_rows  [$];

    int idle_pct;
    int stall_pct;
    int errors;
    int items_sent;
    int results_seen;
    int bytes_seen;
    int idle_by_phase  [4] = '{0, 79, 0, 30};
    int stall_by_phase [4] = '{0, 0, 79, 30};

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic t_seg_item make_item(logic [63:0] pos, logic [7:0] val,
                                            logic has, logic sl, logic eof);
        t_seg_item it;
        it.pos      = pos;
        it.val      = val;
        it.has      = has;
        it.seg_last = sl;
        it.eof      = eof;
        return it;
    endfunction

    // Hand-typed rows always expect one result, never an ended stream
    function automatic t_dir_row make_row(logic [63:0] pos, logic [7:0] val, logic has,
                                          logic sl, logic eof, logic fixed,
                                          logic [7:0] data, logic carries,
                                          logic [63:0] assembled, logic [5:0] pend);
        t_dir_row r;
        r.item           = make_item(pos, val, has, sl, eof);
        r.fixed          = fixed;
        r.want.data      = data;
        r.want.carries   = carries;
        r.want.ended     = 1'b0;
        r.want.assembled = assembled;
        r.want.pend      = pend;
        r.want.none_pend = (pend == 0);
        r.want.last      = 1'b1;
        return r;
    endfunction

    function automatic t_rel_word status_word(logic [7:0] data, logic carries, logic ended);
        t_rel_word w;
        w.data      = data;
        w.carries   = carries;
        w.ended     = ended;
        w.assembled = asm_pos;
        w.pend      = pend_cnt[PEND_W-1:0];
        w.none_pend = (pend_cnt == 0);
        w.last      = 1'b0;
        return w;
    endfunction

    // Park the byte, update the end marker, then release every contiguous byte
    task automatic reassemble(input t_seg_item it);
        int unsigned slot;
        logic        keep;
        logic [63:0] e;
        t_rel_word   w;
        step_out.delete();
        if (it.has) begin
            keep = 1'b1;
            if (it.pos < asm_pos)
                keep = 1'b0;
            else if (it.pos - asm_pos >= 64'(CAP))
                keep = 1'b0;
            if (end_set && it.pos >= end_at)
                keep = 1'b0;
            if (keep) begin
                slot = 32'(it.pos % CAP);
                // never overwrite a byte already held
                if (!held_ok[slot]) begin
                    held_ok[slot]   = 1'b1;
                    held_byte[slot] = it.val;
                    pend_cnt++;
                end
            end
        end
        if (it.seg_last && it.eof) begin
            e = it.pos;
            if (it.has && it.pos != {POS_W{1'b1}})
                e = it.pos + 1;
            end_at  = e;
            end_set = 1'b1;
        end
        forever begin
            slot = 32'(asm_pos % CAP);
            if (!held_ok[slot])
                break;
            if (end_set && asm_pos == end_at)
                break;
            held_ok[slot] = 1'b0;
            if (pend_cnt > 0)
                pend_cnt--;
            asm_pos++;
            step_out.insert(step_out.size(), status_word(held_byte[slot], 1'b1, 1'b0));
        end
        if (end_set && asm_pos == end_at)
            stream_done = 1'b1;
        if (step_out.size() == 0 || stream_done)
            step_out.insert(step_out.size(), status_word(8'h00, 1'b0, stream_done));
        w      = step_out[step_out.size() - 1];
        w.last = 1'b1;
        step_out[step_out.size() - 1] = w;
    endtask

    // Offer one item after a random gap; hold it until the transfer happens
    task automatic send_item(input t_seg_item it, input logic fixed, input t_rel_word want);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.val, it.pos};
        s_axis_tuser  <= {it.eof, it.has};
        s_axis_tlast  <= it.seg_last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        reassemble(it);
        if (fixed)
            release_q.insert(release_q.size(), want);
        else
            foreach (step_out[k])
                release_q.insert(release_q.size(), step_out[k]);
        items_sent++;
    endtask

    // Drop valid and hold until every owed result has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (release_q.size() != 0);
    endtask

    // Shuffled segments over the window ahead, with duplicates, noise and end markers
    task automatic run_batch();
        t_seg_item        seq [$];
        t_seg_item        it;
        logic [POS_W-1:0] order [$];
        logic [POS_W-1:0] base;
        logic [POS_W-1:0] tmp;
        int               span;
        int               seglen;
        int               k;
        int               j;
        int               t;
        logic             need_far;
        base     = asm_pos;
        span     = $urandom_range(36, 1);
        need_far = 1'b0;
        for (k = 0; k < span; k++)
            order.insert(order.size(), base + 64'(k));
        for (k = span - 1; k > 0; k--) begin
            j        = $urandom_range(k, 0);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        k = 0;
        while (k < span) begin
            seglen = $urandom_range(4, 1);
            for (t = 0; t < seglen && k < span; t++) begin
                it = make_item(order[k], 8'($urandom), 1'b1, 1'b0, 1'b0);
                it.seg_last = (t == seglen - 1) || (k == span - 1);
                // eof off the last item is ignored by the block
                it.eof = !it.seg_last && ($urandom_range(9) == 0);
                seq.insert(seq.size(), it);
                if ($urandom_range(5) == 0) begin
                    it.val      = 8'($urandom);
                    it.seg_last = 1'b1;
                    it.eof      = 1'b0;
                    seq.insert(seq.size(), it);
                end
                if ($urandom_range(7) == 0) begin
                    it = make_item({$urandom, $urandom}, 8'($urandom), 1'b1,
                                   1'($urandom_range(1)), 1'b0);
                    case ($urandom_range(3))
                        1: it.pos = (base > 0) ? 64'($urandom_range(base[31:0] - 1, 0))
                                               : {POS_W{1'b1}};
                        2: it.has = 1'b0;
                        3: it.pos = base + CAP + $urandom_range(40, 0);
                        default: ;
                    endcase
                    seq.insert(seq.size(), it);
                end
                k++;
            end
        end
        // end below the assembled point stalls everything until a far end replaces it
        if (base > 0 && $urandom_range(7) == 0) begin
            it = make_item(64'($urandom_range(base[31:0] - 1, 0)), 8'($urandom), 1'b0,
                           1'b1, 1'b1);
            seq.insert($urandom_range(seq.size() - 1, 0), it);
            need_far = 1'b1;
        end
        if (need_far || $urandom_range(4) == 0) begin
            it = make_item(base + 64'h1_0000_0000 + $urandom, 8'($urandom),
                           1'($urandom_range(1)), 1'b1, 1'b1);
            seq.insert(seq.size(), it);
        end
        foreach (seq[n])
            send_item(seq[n], 1'b0, '0);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
        errors++;
        if (errors <= 40)
            $display("[%0t] result %0d %s: got %0h, want %0h",
                     $time, results_seen, what, got_v, want_v);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare every master transfer against the oldest owed result
    always @(posedge i_clk) begin : watch_results
        t_rel_word got;
        t_rel_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tdata[8],
                   m_axis_tdata[72:9], m_axis_tdata[78:73], m_axis_tdata[79],
                   m_axis_tlast};
            results_seen++;
            if (got.carries)
                bytes_seen++;
            if (release_q.size() == 0) begin
                flag_mismatch("arrived with nothing owed", 64'(got), 64'(0));
            end else begin
                want = release_q.pop_front();
                if (got.data != want.data)
                    flag_mismatch("out_byte", 64'(got.data), 64'(want.data));
                if (got.carries != want.carries)
                    flag_mismatch("out_valid", 64'(got.carries), 64'(want.carries));
                if (got.ended != want.ended)
                    flag_mismatch("stream_ended", 64'(got.ended), 64'(want.ended));
                if (got.assembled != want.assembled)
                    flag_mismatch("assembled_count", got.assembled, want.assembled);
                if (got.pend != want.pend)
                    flag_mismatch("pending_count", 64'(got.pend), 64'(want.pend));
                if (got.none_pend != want.none_pend)
                    flag_mismatch("nothing_pending", 64'(got.none_pend),
                                  64'(want.none_pend));
                if (got.last != want.last)
                    flag_mismatch("tlast", 64'(got.last), 64'(want.last));
            end
        end
    end

    initial begin : stimulus
        int          p;
        int          k;
        int          mark;
        logic [63:0] base;
        logic [63:0] all1;
        all1          = {POS_W{1'b1}};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        errors        = 0;
        items_sent    = 0;
        results_seen  = 0;
        bytes_seen    = 0;
        asm_pos       = '0;
        pend_cnt      = 0;
        end_set       = 1'b0;
        end_at        = '0;
        stream_done   = 1'b0;
        for (k = 0; k < CAP; k++) begin
            held_ok[k]   = 1'b0;
            held_byte[k] = '0;
        end

        //                                        pos   val    has sl eof fix data v asm pend
        dir_rows.insert(dir_rows.size(), make_row(0,    8'h00, 0, 1, 0, 1, 8'h00, 0, 0, 0));
        // beyond the window, just past the window edge, then a duplicate
        dir_rows.insert(dir_rows.size(), make_row(40,   8'h3C, 1, 1, 0, 1, 8'h00, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), make_row(5,    8'hFF, 1, 0, 0, 1, 8'h00, 0, 0, 1));
        dir_rows.insert(dir_rows.size(), make_row(31,   8'h00, 1, 1, 0, 1, 8'h00, 0, 0, 2));
        dir_rows.insert(dir_rows.size(), make_row(32,   8'h77, 1, 1, 0, 1, 8'h00, 0, 0, 2));
        dir_rows.insert(dir_rows.size(), make_row(5,    8'h11, 1, 1, 0, 1, 8'h00, 0, 0, 2));
        dir_rows.insert(dir_rows.size(), make_row(0,    8'hA5, 1, 1, 0, 1, 8'hA5, 1, 1, 2));
        dir_rows.insert(dir_rows.size(), make_row(all1, 8'h5A, 1, 1, 0, 1, 8'h00, 0, 1, 2));
        dir_rows.insert(dir_rows.size(), make_row(1,    8'h01, 1, 0, 0, 1, 8'h01, 1, 2, 2));
        // eof off the segment's last item is ignored
        dir_rows.insert(dir_rows.size(), make_row(3,    8'h33, 1, 0, 1, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), make_row(2,    8'h22, 1, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), make_row(4,    8'h44, 1, 1, 0, 0, 0, 0, 0, 0));
        // end set by a byte, then a byte past the end
        dir_rows.insert(dir_rows.size(), make_row(7,    8'h70, 1, 1, 1, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), make_row(9,    8'h99, 1, 1, 0, 0, 0, 0, 0, 0));
        // end moved below the assembled point: everything is dropped
        dir_rows.insert(dir_rows.size(), make_row(2,    8'h00, 0, 1, 1, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), make_row(8,    8'h88, 1, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), make_row(6,    8'h66, 1, 1, 0, 0, 0, 0, 0, 0));
        // end at the top of the position space, marker then saturating byte
        dir_rows.insert(dir_rows.size(), make_row(all1, 8'h00, 0, 1, 1, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), make_row(all1, 8'h80, 1, 1, 1, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), make_row(6,    8'h66, 1, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), make_row(8,    8'h00, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), make_row(0,    8'h00, 0, 0, 1, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), make_row(8,    8'h7F, 1, 1, 0, 0, 0, 0, 0, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].item, dir_rows[r].fixed, dir_rows[r].want);
        drain();

        // Random traffic under each idling mix; drain between mixes
        for (p = 0; p < 4; p++) begin
            idle_pct  = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            mark      = items_sent;
            while (items_sent - mark < 68)
                run_batch();
            drain();
        end

        // Flush the window in order so nothing stale is held
        base = asm_pos;
        for (k = 0; k < CAP + 2; k++)
            send_item(make_item(base + 64'(k), 8'($urandom), 1'b1, 1'b1, 1'b0), 1'b0, '0);

        // End the stream with a byte parked past the end, then move the end on
        base = asm_pos;
        send_item(make_item(base + 3,  8'($urandom), 1'b1, 1'b1, 1'b0), 1'b0, '0);
        send_item(make_item(base + 2,  8'h00,        1'b0, 1'b1, 1'b1), 1'b0, '0);
        send_item(make_item(base + 1,  8'($urandom), 1'b1, 1'b1, 1'b0), 1'b0, '0);
        send_item(make_item(base,      8'($urandom), 1'b1, 1'b1, 1'b0), 1'b0, '0);
        send_item(make_item(base + 2,  8'($urandom), 1'b1, 1'b1, 1'b0), 1'b0, '0);
        send_item(make_item(base + 10, 8'h00,        1'b0, 1'b1, 1'b1), 1'b0, '0);
        send_item(make_item(base + 2,  8'($urandom), 1'b1, 1'b1, 1'b0), 1'b0, '0);
        send_item(make_item(base + 9,  8'($urandom), 1'b1, 1'b1, 1'b0), 1'b0, '0);
        send_item(make_item(base + 12, 8'($urandom), 1'b1, 1'b1, 1'b0), 1'b0, '0);
        send_item(make_item(base + 4,  8'h00,        1'b0, 1'b1, 1'b0), 1'b0, '0);

        drain();
        repeat (40) @(posedge i_clk);

        $display("Sent %0d stream items; checked %0d results, %0d of them released bytes.",
                 items_sent, results_seen, bytes_seen);
        $display("Final assembled position %0d, stream end reached: %0d.",
                 asm_pos, stream_done);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/srb_pkg.sv
hw/rtl/srb_ram.sv
hw/rtl/srb_ctrl.sv
hw/rtl/srb_dp.sv
hw/rtl/stream_reorder_buffer_core.sv
tb/sv/stream_reorder_buffer_core_tb.sv
